// ===== rtl/tvsl_pkg.sv =====
// Package for the layer-4 load balancer with source NAT.
// Holds item structs, register indexes, verdict codes and reset values.
package tvsl_pkg;

  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TupleW = 48;

  localparam logic [CfgIdxW-1:0] REG_VIP_ADDR     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VIP_PORT     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NAT_ADDR     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BACKEND_ADDR = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BACKEND_PORT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NAT_PORT_LO  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_NAT_PORT_HI  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MAX_TCP_LEN  = 3'd7;

  localparam logic [1:0] VERDICT_PASS = 2'd0;
  localparam logic [1:0] VERDICT_DROP = 2'd1;
  localparam logic [1:0] VERDICT_TX   = 2'd2;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  localparam logic [31:0] RST_VIP_ADDR     = 32'hAC13000A;
  localparam logic [15:0] RST_VIP_PORT     = 16'd80;
  localparam logic [31:0] RST_NAT_ADDR     = 32'hAC130005;
  localparam logic [31:0] RST_BACKEND_ADDR = 32'hAC130002;
  localparam logic [15:0] RST_BACKEND_PORT = 16'd80;
  localparam logic [15:0] RST_NAT_PORT_LO  = 16'd30100;
  localparam logic [15:0] RST_NAT_PORT_HI  = 16'd60900;
  localparam logic [15:0] RST_MAX_TCP_LEN  = 16'd1480;

  typedef struct packed {
    logic [15:0] captured_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] ip_total_len;
    logic [3:0]  ip_header_words;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic        mac_select;
    logic        new_mapping;
    logic [15:0] tcp_length;
  } out_item_t;

  // Command broadcast down the cell row
  typedef struct packed {
    logic              lookup;  // compare key against entry
    logic              write;   // store key/value at first free or hit
    logic [TupleW-1:0] key;
    logic [TupleW-1:0] value;
  } cell_cmd_t;

  // Token rippling along the row, one cell per cycle
  typedef struct packed {
    logic              hit;     // match found upstream
    logic              free;    // free entry already claimed upstream
    logic [TupleW-1:0] value;   // value from the matching entry
  } cell_tok_t;

endpackage

// ===== rtl/tcp_vip_snat_load_balancer_unit.sv =====
// Layer-4 load balancer with source NAT. An item is taken when start is high
// and busy low; busy then holds until the result strobes for one cycle and
// cannot be stalled. Each table is a row of TABLE_ENTRIES cells walked by a
// token one cell a cycle. An item that is passed or dropped early skips the
// tables; otherwise it takes a lookup pass on both tables, and when a new
// translation is written, a lookup pass and then a write pass.
module tcp_vip_snat_load_balancer_unit #(
  parameter int unsigned TABLE_ENTRIES = tvsl_pkg::TableEntriesDef
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  tvsl_pkg::in_item_t                   in_item,
  output logic                                 out_strobe,
  output tvsl_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [tvsl_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [tvsl_pkg::CfgDataW-1:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLASS = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Configuration registers
  logic [31:0] vip_addr_r, nat_addr_r, backend_addr_r;
  logic [15:0] vip_port_r, backend_port_r, nat_lo_r, nat_hi_r, max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vip_addr_r     <= tvsl_pkg::RST_VIP_ADDR;
      vip_port_r     <= tvsl_pkg::RST_VIP_PORT;
      nat_addr_r     <= tvsl_pkg::RST_NAT_ADDR;
      backend_addr_r <= tvsl_pkg::RST_BACKEND_ADDR;
      backend_port_r <= tvsl_pkg::RST_BACKEND_PORT;
      nat_lo_r       <= tvsl_pkg::RST_NAT_PORT_LO;
      nat_hi_r       <= tvsl_pkg::RST_NAT_PORT_HI;
      max_len_r      <= tvsl_pkg::RST_MAX_TCP_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvsl_pkg::REG_VIP_ADDR:     vip_addr_r     <= cfg_data;
        tvsl_pkg::REG_VIP_PORT:     vip_port_r     <= cfg_data[15:0];
        tvsl_pkg::REG_NAT_ADDR:     nat_addr_r     <= cfg_data;
        tvsl_pkg::REG_BACKEND_ADDR: backend_addr_r <= cfg_data;
        tvsl_pkg::REG_BACKEND_PORT: backend_port_r <= cfg_data[15:0];
        tvsl_pkg::REG_NAT_PORT_LO:  nat_lo_r       <= cfg_data[15:0];
        tvsl_pkg::REG_NAT_PORT_HI:  nat_hi_r       <= cfg_data[15:0];
        tvsl_pkg::REG_MAX_TCP_LEN:  max_len_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Control and item registers
  logic [2:0]                state_r, state_nxt;
  tvsl_pkg::in_item_t        item_r;
  logic                      fwd_r, fwd_nxt;     // towards backend
  logic [15:0]               port_cnt_r, port_cnt_nxt;
  logic [15:0]               nat_port_r, nat_port_nxt;
  logic                      go_r, go_nxt;
  logic                      wr_r, wr_nxt;
  tvsl_pkg::out_item_t       res_r, res_nxt;
  logic                      strobe_r, strobe_nxt;

  // Table side
  tvsl_pkg::cell_cmd_t       fcmd, rcmd;
  logic                      fdone, fhit, fwr, rdone, rhit, rwr;
  logic [tvsl_pkg::TupleW-1:0] fval, rval;
  logic [tvsl_pkg::TupleW-1:0] cli_key, nat_key;

  logic [15:0] tlen;
  logic        early_pass;

  assign early_pass = (item_r.captured_len < 16'd54) ||
                      (item_r.ether_type != tvsl_pkg::ETYPE_IPV4) ||
                      (item_r.ip_protocol != tvsl_pkg::PROTO_TCP);
  assign tlen    = item_r.ip_total_len - {10'd0, item_r.ip_header_words, 2'b00};
  assign cli_key = {item_r.src_ip, item_r.src_port};
  assign nat_key = fwd_r ? {nat_addr_r, nat_port_r} : {item_r.dst_ip, item_r.dst_port};

  always_comb begin
    fcmd = '0;
    rcmd = '0;
    fcmd.key    = cli_key;
    fcmd.value  = {nat_addr_r, nat_port_r};
    rcmd.key    = nat_key;
    rcmd.value  = cli_key;
    fcmd.lookup = fwd_r && !wr_r;
    fcmd.write  = wr_r;
    rcmd.lookup = !fwd_r || wr_r;
    rcmd.write  = wr_r;
  end

  tvsl_table #(.ENTRIES(TABLE_ENTRIES)) u_fwd (
    .clk(clk), .rst_n(rst_n), .go(go_r), .cmd(fcmd),
    .done(fdone), .hit(fhit), .written(fwr), .value(fval)
  );

  tvsl_table #(.ENTRIES(TABLE_ENTRIES)) u_rev (
    .clk(clk), .rst_n(rst_n), .go(go_r), .cmd(rcmd),
    .done(rdone), .hit(rhit), .written(rwr), .value(rval)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    fwd_nxt      = fwd_r;
    port_cnt_nxt = port_cnt_r;
    nat_port_nxt = nat_port_r;
    go_nxt       = 1'b0;
    wr_nxt       = wr_r;
    res_nxt      = res_r;
    strobe_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        res_nxt = '0;
        wr_nxt  = 1'b0;
        fwd_nxt = (item_r.dst_ip == vip_addr_r);
        if (early_pass) begin
          state_nxt = ST_OUT;
        end else begin
          res_nxt.tcp_length = tlen;
          if (tlen > max_len_r) begin
            res_nxt.verdict = tvsl_pkg::VERDICT_DROP;
            state_nxt = ST_OUT;
          end else if (item_r.dst_ip == vip_addr_r &&
                       item_r.dst_port != vip_port_r) begin
            res_nxt.verdict = tvsl_pkg::VERDICT_DROP;
            state_nxt = ST_OUT;
          end else begin
            go_nxt    = 1'b1;
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (fdone && rdone) begin
          res_nxt.verdict = tvsl_pkg::VERDICT_TX;
          if (fwd_r) begin
            res_nxt.out_dst_ip   = backend_addr_r;
            res_nxt.out_dst_port = backend_port_r;
            if (fhit) begin
              res_nxt.out_src_ip   = fval[47:16];
              res_nxt.out_src_port = fval[15:0];
              state_nxt = ST_OUT;
            end else begin
              // Allocate a port and run the write pass on both tables
              nat_port_nxt = port_cnt_r + nat_lo_r;
              port_cnt_nxt = (nat_port_nxt == nat_hi_r) ? 16'd0 : port_cnt_r + 16'd1;
              res_nxt.out_src_ip   = nat_addr_r;
              res_nxt.out_src_port = nat_port_nxt;
              res_nxt.new_mapping  = 1'b1;
              wr_nxt    = 1'b1;
              go_nxt    = 1'b1;
              state_nxt = ST_WRITE;
            end
          end else if (rhit) begin
            res_nxt.out_src_ip   = vip_addr_r;
            res_nxt.out_src_port = vip_port_r;
            res_nxt.out_dst_ip   = rval[47:16];
            res_nxt.out_dst_port = rval[15:0];
            res_nxt.mac_select   = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            res_nxt.verdict = tvsl_pkg::VERDICT_PASS;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_WRITE: begin
        if (fdone && rdone) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      port_cnt_r <= '0;
      go_r       <= 1'b0;
      wr_r       <= 1'b0;
      strobe_r   <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      port_cnt_r <= port_cnt_nxt;
      go_r       <= go_nxt;
      wr_r       <= wr_nxt;
      strobe_r   <= strobe_nxt;
      fwd_r      <= fwd_nxt;
    end
    if (state_r == ST_IDLE && start) item_r <= in_item;
    nat_port_r <= nat_port_nxt;
    res_r      <= res_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule

// ===== rtl/tvsl_cell.sv =====
// One entry of an associative table: key, value, valid.
// Depends on tvsl_pkg. Takes the token from its left neighbour each cycle.
module tvsl_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tvsl_pkg::cell_cmd_t    cmd,
  input  logic                   tok_vld_in,
  input  tvsl_pkg::cell_tok_t    tok_in,
  output logic                   tok_vld_out,
  output tvsl_pkg::cell_tok_t    tok_out
);

  logic                            vld_r;
  logic [tvsl_pkg::TupleW-1:0]     key_r;
  logic [tvsl_pkg::TupleW-1:0]     val_r;
  logic                            tok_vld_r;
  tvsl_pkg::cell_tok_t             tok_r;
  logic                            match;
  logic                            take;
  tvsl_pkg::cell_tok_t             tok_nxt;

  assign match = vld_r && (key_r == cmd.key);
  // A write claims this entry on a hit, or when it is the first free one.
  // Entries fill from the left and are never freed, so any hit lies
  // upstream of the first free entry and has already set hit there.
  assign take = tok_vld_in && cmd.write &&
                (match || (!tok_in.hit && !tok_in.free && !vld_r));

  always_comb begin
    tok_nxt = tok_in;
    if (tok_vld_in && cmd.lookup && !tok_in.hit && match) begin
      tok_nxt.hit   = 1'b1;
      tok_nxt.value = val_r;
    end
    if (take && !match) tok_nxt.free = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
      if (take) vld_r <= 1'b1;
    end
    tok_r <= tok_nxt;
    if (take) begin
      key_r <= cmd.key;
      val_r <= cmd.value;
    end
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

// ===== rtl/tvsl_table.sv =====
// Associative table built as a row of tvsl_cell, token ripples end to end.
// Depends on tvsl_pkg and tvsl_cell.
module tvsl_table #(
  parameter int unsigned ENTRIES = tvsl_pkg::TableEntriesDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  tvsl_pkg::cell_cmd_t          cmd,
  output logic                         done,
  output logic                         hit,
  output logic                         written,
  output logic [tvsl_pkg::TupleW-1:0]  value
);

  logic                vld_chain [ENTRIES+1];
  tvsl_pkg::cell_tok_t tok_chain [ENTRIES+1];

  assign vld_chain[0] = go;
  assign tok_chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tvsl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .tok_vld_in  (vld_chain[g]),
      .tok_in      (tok_chain[g]),
      .tok_vld_out (vld_chain[g+1]),
      .tok_out     (tok_chain[g+1])
    );
  end

  assign done    = vld_chain[ENTRIES];
  assign hit     = tok_chain[ENTRIES].hit;
  assign written = tok_chain[ENTRIES].free;
  assign value   = tok_chain[ENTRIES].value;

endmodule

// ===== rtl/tvsl_checker.sv =====
// Port-level checks for the load balancer top level, bound in below.
// Depends on tvsl_pkg.
module tvsl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input tvsl_pkg::out_item_t  out_item
);

  // Taking an item makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after start");

  // Single-cycle result strobe
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");

  // Block is already idle while its result is shown
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy while result shown");

  // Never an unused verdict code
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.verdict != 2'd3) else $error("bad verdict");

  // Pass or drop carries no rewrite flags
  a_plain_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.verdict != tvsl_pkg::VERDICT_TX |->
    !out_item.new_mapping && !out_item.mac_select) else $error("flags on plain result");

endmodule

bind tcp_vip_snat_load_balancer_unit tvsl_checker u_tvsl_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_item(out_item)
);
